// ===== rtl/core/i2c_sccb_register_master_assert.svh =====
// Assertion macros shared by the checker of the I2C/SCCB register master.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef I2C_SCCB_REGISTER_MASTER_ASSERT_SVH
`define I2C_SCCB_REGISTER_MASTER_ASSERT_SVH

// Property checked outside reset only.
`define ISRM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define ISRM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/isrm_pkg.sv =====
// Types, codes and constant tables of the I2C/SCCB register master.
// No dependencies; used by every module of the block.
package isrm_pkg;

    localparam logic [15:0] HALF_RESET = 16'd120;

    typedef enum logic [1:0] {
        FUNC_NONE  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_RSVD  = 2'd3
    } t_func;

    typedef enum logic {
        REG_HALF_PERIOD = 1'b0,
        REG_SCCB_MODE   = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [1:0] func;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic       sda_level;
    } t_in;

    typedef struct packed {
        logic       scl_level;
        logic       sda_out_level;
        logic       sda_is_output;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_missing;
    } t_out;

    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic        sccb_mode;
    } t_cfg;

    typedef struct packed {
        logic [1:0] func;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
    } t_req;

    typedef struct packed {
        logic drive;
        logic sda;
        logic scl;
    } t_pins;

    typedef enum logic [18:0] {
        ST_IDLE     = 19'h00001,
        ST_START_A  = 19'h00002,
        ST_START_B  = 19'h00004,
        ST_BIT_LO   = 19'h00008,
        ST_BIT_HI   = 19'h00010,
        ST_ACK_LO   = 19'h00020,
        ST_ACK_HI   = 19'h00040,
        ST_ACK_TAIL = 19'h00080,
        ST_STOP_A   = 19'h00100,
        ST_STOP_B   = 19'h00200,
        ST_STOP_C   = 19'h00400,
        ST_RD_PRE   = 19'h00800,
        ST_RD_A     = 19'h01000,
        ST_RD_B     = 19'h02000,
        ST_RD_C     = 19'h04000,
        ST_NK_A     = 19'h08000,
        ST_NK_B     = 19'h10000,
        ST_NK_C     = 19'h20000,
        ST_NK_D     = 19'h40000
    } t_step;

    typedef enum logic [3:0] {
        K_START   = 4'd0,
        K_ADDRW   = 4'd1,
        K_REG     = 4'd2,
        K_DATA    = 4'd3,
        K_MIDSTOP = 4'd4,
        K_ADDRR   = 4'd5,
        K_READ    = 4'd6,
        K_STOP    = 4'd7,
        K_END     = 4'd8
    } t_kind;

    // Order of bus phases for each request type.
    function automatic t_kind plan_kind(input logic is_read, input logic [3:0] stage);
        t_kind k;
        k = K_END;
        if (is_read) begin
            case (stage)
                4'd0:    k = K_START;
                4'd1:    k = K_ADDRW;
                4'd2:    k = K_REG;
                4'd3:    k = K_MIDSTOP;
                4'd4:    k = K_START;
                4'd5:    k = K_ADDRR;
                4'd6:    k = K_READ;
                4'd7:    k = K_STOP;
                default: k = K_END;
            endcase
        end else begin
            case (stage)
                4'd0:    k = K_START;
                4'd1:    k = K_ADDRW;
                4'd2:    k = K_REG;
                4'd3:    k = K_DATA;
                4'd4:    k = K_STOP;
                default: k = K_END;
            endcase
        end
        return k;
    endfunction

    // Pin levels set on entry to a bus slot.
    function automatic t_pins enter_pins(input t_step s, input t_pins p, input logic msb);
        t_pins q;
        q = p;
        case (s)
            ST_START_A:  begin q.scl = 1'b1; q.sda = 1'b1; q.drive = 1'b1; end
            ST_START_B:  begin q.sda = 1'b0; end
            ST_BIT_LO:   begin q.scl = 1'b0; q.sda = msb; q.drive = 1'b1; end
            ST_BIT_HI:   begin q.scl = 1'b1; end
            ST_ACK_LO:   begin q.scl = 1'b0; q.drive = 1'b0; end
            ST_ACK_HI:   begin q.scl = 1'b1; end
            ST_ACK_TAIL: begin q.scl = 1'b0; q.drive = 1'b1; end
            ST_STOP_A:   begin q.scl = 1'b0; q.sda = 1'b0; q.drive = 1'b1; end
            ST_STOP_B:   begin q.scl = 1'b1; end
            ST_STOP_C:   begin q.sda = 1'b1; end
            ST_RD_PRE:   begin q.scl = 1'b0; end
            ST_RD_A:     begin q.sda = 1'b1; q.drive = 1'b0; end
            ST_RD_B:     begin q.scl = 1'b0; end
            ST_RD_C:     begin q.scl = 1'b1; end
            ST_NK_A:     begin q.scl = 1'b0; q.drive = 1'b1; end
            ST_NK_B:     begin q.scl = 1'b0; q.sda = 1'b1; end
            ST_NK_C:     begin q.scl = 1'b1; end
            ST_NK_D:     begin q.scl = 1'b0; end
            default:     q = p;
        endcase
        return q;
    endfunction

endpackage

// ===== rtl/core/i2c_sccb_register_master.sv =====
// Top level of the I2C/SCCB register master: input register, sequencer, result register.
// Depends on isrm_pkg and isrm_sequencer.
//
// Usage. Every transfer on the input channel is one bus tick: it carries the
// request fields (only looked at while the bus is idle) and the sampled SDA
// level. Every tick yields exactly one result transfer with the driven SCL/SDA
// levels, the SDA drive enable, busy, a one-tick done pulse, the last byte
// read and the missing-acknowledge flag.
// Result path: a tick accepted into the input register is stepped by the
// sequencer, captured in the result register and offered from there.
// Throughput: one tick per cycle while the receiver is ready; the sequencer performs one
// complete step of the bus state machine per enabled cycle from its registered state.
// Stalls: when the receiver holds ready low, the result register holds, the
// input register fills and input ready then drops; nothing is lost.
// Reset: synchronous, active low; the bus idles with SCL and SDA driven high,
// half_period_ticks returns to 120 and sccb_mode to 0. Configuration writes
// take effect at once and are meant for idle periods.
module i2c_sccb_register_master
    import isrm_pkg::*;
#(
    parameter int DELAY_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic r_in_valid;
    t_in  r_in_data;
    logic r_out_valid;
    t_out r_out_data;
    t_cfg r_cfg;
    logic step_en;
    t_out step_result;

    assign step_en    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= HALF_RESET;
            r_cfg.sccb_mode         <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HALF_PERIOD: r_cfg.half_period_ticks <= i_cfg_data;
                REG_SCCB_MODE:   r_cfg.sccb_mode         <= i_cfg_data[0];
                default:         r_cfg                   <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    isrm_sequencer #(
        .DELAY_BITS (DELAY_BITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (step_en),
        .i_item   (r_in_data),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_en) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_en) begin
            r_out_data <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/core/isrm_sequencer.sv =====
// Bus sequencer of the I2C/SCCB register master: advances one tick per enable.
// Depends on isrm_pkg.
module isrm_sequencer
    import isrm_pkg::*;
#(
    parameter int DELAY_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_in  i_item,
    input  t_cfg i_cfg,
    output t_out o_result
);

    localparam int CW = (DELAY_BITS > 16) ? DELAY_BITS : 16;
    localparam logic [CW-1:0] CMASK = CW'({DELAY_BITS{1'b1}});

    t_step                 r_step,  n_step;
    logic [DELAY_BITS-1:0] r_delay, n_delay;
    logic [7:0]            r_shift, n_shift;
    logic [3:0]            r_bitc,  n_bitc;
    t_req                  r_req,   n_req;
    logic [7:0]            r_recv,  n_recv;
    logic                  r_fault, n_fault;
    t_pins                 r_pins,  n_pins;
    logic [3:0]            r_stage, n_stage;

    logic                  done;
    logic                  do_adv;
    logic                  enter_en;
    t_step                 enter_st;
    logic [CW-1:0]         half_w;
    logic [CW-1:0]         limit;
    logic [DELAY_BITS-1:0] cnt;
    logic                  is_read;
    logic [3:0]            adv_stage;
    t_kind                 adv_kind;

    always_comb begin
        half_w = CW'(i_cfg.half_period_ticks);
        limit  = (half_w > CMASK) ? CMASK : half_w;
        if (limit == '0) begin
            limit = CW'(1);
        end
    end

    always_comb begin
        n_step   = r_step;
        n_delay  = r_delay;
        n_shift  = r_shift;
        n_bitc   = r_bitc;
        n_req    = r_req;
        n_recv   = r_recv;
        n_fault  = r_fault;
        n_pins   = r_pins;
        n_stage  = r_stage;
        done     = 1'b0;
        do_adv   = 1'b0;
        enter_en = 1'b0;
        enter_st = ST_IDLE;
        cnt      = r_delay + 1'b1;
        is_read  = (r_req.func == FUNC_READ);
        adv_stage = r_stage + 4'd1;
        adv_kind  = plan_kind(is_read, adv_stage);

        if (r_step == ST_IDLE) begin
            if (i_item.func == FUNC_WRITE || i_item.func == FUNC_READ) begin
                n_req.func             = i_item.func;
                n_req.device_address   = i_item.device_address;
                n_req.register_address = i_item.register_address;
                n_req.write_data       = i_item.write_data;
                n_fault  = 1'b0;
                n_stage  = '0;
                enter_en = 1'b1;
                enter_st = ST_START_A;
            end
        end else if (CW'(cnt) >= limit) begin
            n_delay = '0;
            case (r_step)
                ST_START_A: begin enter_en = 1'b1; enter_st = ST_START_B; end
                ST_START_B: begin n_pins.scl = 1'b0; do_adv = 1'b1; end
                ST_BIT_LO:  begin enter_en = 1'b1; enter_st = ST_BIT_HI; end
                ST_BIT_HI: begin
                    n_shift  = {r_shift[6:0], 1'b0};
                    n_bitc   = r_bitc + 4'd1;
                    enter_en = 1'b1;
                    enter_st = n_bitc[3] ? ST_ACK_LO : ST_BIT_LO;
                end
                ST_ACK_LO:  begin enter_en = 1'b1; enter_st = ST_ACK_HI; end
                ST_ACK_HI: begin
                    // A high acknowledge is recorded and the trailing low slot is skipped.
                    if (i_item.sda_level) begin
                        n_fault      = 1'b1;
                        n_pins.drive = 1'b1;
                        n_pins.scl   = 1'b0;
                        do_adv       = 1'b1;
                    end else begin
                        enter_en = 1'b1;
                        enter_st = ST_ACK_TAIL;
                    end
                end
                ST_ACK_TAIL: do_adv = 1'b1;
                ST_STOP_A:  begin enter_en = 1'b1; enter_st = ST_STOP_B; end
                ST_STOP_B:  begin enter_en = 1'b1; enter_st = ST_STOP_C; end
                ST_STOP_C:  do_adv = 1'b1;
                ST_RD_PRE:  begin enter_en = 1'b1; enter_st = ST_RD_A; end
                ST_RD_A:    begin enter_en = 1'b1; enter_st = ST_RD_B; end
                ST_RD_B:    begin enter_en = 1'b1; enter_st = ST_RD_C; end
                ST_RD_C: begin
                    n_shift  = {r_shift[6:0], i_item.sda_level};
                    n_bitc   = r_bitc + 4'd1;
                    enter_en = 1'b1;
                    if (n_bitc[3]) begin
                        n_recv   = n_shift;
                        enter_st = ST_NK_A;
                    end else begin
                        enter_st = ST_RD_A;
                    end
                end
                ST_NK_A:    begin enter_en = 1'b1; enter_st = ST_NK_B; end
                ST_NK_B:    begin enter_en = 1'b1; enter_st = ST_NK_C; end
                ST_NK_C:    begin enter_en = 1'b1; enter_st = ST_NK_D; end
                ST_NK_D:    do_adv = 1'b1;
                default:    n_step = ST_IDLE;
            endcase
        end else begin
            n_delay = cnt;
        end

        if (do_adv) begin
            // The mid-read stop is skipped in plain I2C mode.
            if (adv_kind == K_MIDSTOP && !i_cfg.sccb_mode) begin
                adv_stage = adv_stage + 4'd1;
                adv_kind  = plan_kind(is_read, adv_stage);
            end
            n_stage = adv_stage;
            case (adv_kind)
                K_START: begin
                    enter_en = 1'b1;
                    enter_st = ST_START_A;
                end
                K_ADDRW: begin
                    n_shift  = {r_req.device_address, 1'b0};
                    n_bitc   = '0;
                    enter_en = 1'b1;
                    enter_st = ST_BIT_LO;
                end
                K_REG: begin
                    n_shift  = r_req.register_address;
                    n_bitc   = '0;
                    enter_en = 1'b1;
                    enter_st = ST_BIT_LO;
                end
                K_DATA: begin
                    n_shift  = r_req.write_data;
                    n_bitc   = '0;
                    enter_en = 1'b1;
                    enter_st = ST_BIT_LO;
                end
                K_MIDSTOP, K_STOP: begin
                    enter_en = 1'b1;
                    enter_st = ST_STOP_A;
                end
                K_ADDRR: begin
                    n_shift  = {r_req.device_address, 1'b1};
                    n_bitc   = '0;
                    enter_en = 1'b1;
                    enter_st = ST_BIT_LO;
                end
                K_READ: begin
                    n_shift  = '0;
                    n_bitc   = '0;
                    enter_en = 1'b1;
                    enter_st = ST_RD_PRE;
                end
                default: begin
                    n_step  = ST_IDLE;
                    n_delay = '0;
                    done    = 1'b1;
                end
            endcase
        end

        if (enter_en) begin
            n_step  = enter_st;
            n_delay = '0;
            n_pins  = enter_pins(enter_st, n_pins, n_shift[7]);
        end
    end

    always_comb begin
        o_result.scl_level     = n_pins.scl;
        o_result.sda_out_level = n_pins.sda;
        o_result.sda_is_output = n_pins.drive;
        o_result.busy_res      = (n_step != ST_IDLE);
        o_result.done_res      = done;
        o_result.read_data     = n_recv;
        o_result.ack_missing   = n_fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ST_IDLE;
            r_delay <= '0;
            r_shift <= '0;
            r_bitc  <= '0;
            r_req   <= '0;
            r_recv  <= '0;
            r_fault <= 1'b0;
            r_pins  <= 3'b111;
            r_stage <= '0;
        end else if (i_en) begin
            r_step  <= n_step;
            r_delay <= n_delay;
            r_shift <= n_shift;
            r_bitc  <= n_bitc;
            r_req   <= n_req;
            r_recv  <= n_recv;
            r_fault <= n_fault;
            r_pins  <= n_pins;
            r_stage <= n_stage;
        end
    end

endmodule

// ===== rtl/core/isrm_checker.sv =====
// Port-level checks of the I2C/SCCB register master, bound to the top level.
// Depends on isrm_pkg and i2c_sccb_register_master_assert.svh.
`include "i2c_sccb_register_master_assert.svh"

module isrm_checker
    import isrm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // A stalled result transfer keeps its payload.
    `ISRM_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "result changed while stalled")

    // The finishing tick already reports the bus as free.
    `ISRM_ASSERT(a_done_not_busy, o_out_valid && o_out_data.done_res |-> !o_out_data.busy_res, "done shown with busy")

    // SDA is released only inside a transaction.
    `ISRM_ASSERT(a_release_busy, o_out_valid && !o_out_data.sda_is_output |-> o_out_data.busy_res, "SDA released while idle")

    // No result is offered straight after reset.
    `ISRM_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind i2c_sccb_register_master isrm_checker u_isrm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== tb/tb_i2c_sccb_register_master.sv =====
`timescale 1ns / 100ps
// Testbench of the I2C/SCCB register master: every tick transfer is mirrored by a
// bus sequencer written here, and every result transfer is checked field by field.
// Depends on isrm_pkg and the i2c_sccb_register_master RTL only.
module tb_i2c_sccb_register_master;
    import isrm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 1200;
    localparam int HOLD_CYCLES = 400;
    localparam int DIR_ROWS    = 11;

    localparam t_out IDLE_LEVELS  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
    localparam t_out START_LEVELS = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_SPARSE_STALL,
        RX_ALTERNATE,
        RX_HEAVY_STALL
    } t_rx_pattern;

    typedef struct packed {
        t_in  stim;
        logic typed;
        t_out want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    // Mirror of the sequencer and its configuration.
    logic [15:0] cfg_half;
    logic        cfg_sccb;
    t_step       bus_step;
    logic [15:0] slot_count;
    logic [7:0]  shift_reg;
    logic [3:0]  bits_done;
    t_req        held_req;
    logic [7:0]  last_rx;
    logic        nack_seen;
    t_pins       pins;
    logic [3:0]  phase_idx;
    logic        seq_done;

    t_out        pending_levels[$];
    t_out        seen_levels;
    t_out        due_levels;
    t_dir_row    dir_rows [DIR_ROWS];

    int          fail_count = 0;
    int          cycle_count = 0;
    int          accepted_items = 0;
    int          burst_left = 0;
    int          hold_left = 0;
    int          rx_left = 0;
    logic        long_hold_done = 1'b0;
    t_rx_pattern rx_pattern = RX_OPEN;

    i2c_sccb_register_master DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** i2c_sccb_register_master: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic t_kind phase_kind(input logic rd, input logic [3:0] idx);
        t_kind k;
        k = K_END;
        case (idx)
            4'd0: k = K_START;
            4'd1: k = K_ADDRW;
            4'd2: k = K_REG;
            4'd3: k = rd ? K_MIDSTOP : K_DATA;
            4'd4: k = rd ? K_START : K_STOP;
            4'd5: if (rd) k = K_ADDRR;
            4'd6: if (rd) k = K_READ;
            4'd7: if (rd) k = K_STOP;
            default: k = K_END;
        endcase
        return k;
    endfunction

    task automatic enter_slot(input t_step s);
        bus_step   = s;
        slot_count = '0;
        case (s)
            ST_START_A:  begin pins.scl = 1'b1; pins.sda = 1'b1; pins.drive = 1'b1; end
            ST_START_B:  pins.sda = 1'b0;
            ST_BIT_LO:   begin pins.scl = 1'b0; pins.sda = shift_reg[7]; pins.drive = 1'b1; end
            ST_BIT_HI:   pins.scl = 1'b1;
            ST_ACK_LO:   begin pins.scl = 1'b0; pins.drive = 1'b0; end
            ST_ACK_HI:   pins.scl = 1'b1;
            ST_ACK_TAIL: begin pins.scl = 1'b0; pins.drive = 1'b1; end
            ST_STOP_A:   begin pins.scl = 1'b0; pins.sda = 1'b0; pins.drive = 1'b1; end
            ST_STOP_B:   pins.scl = 1'b1;
            ST_STOP_C:   pins.sda = 1'b1;
            ST_RD_PRE:   pins.scl = 1'b0;
            ST_RD_A:     begin pins.sda = 1'b1; pins.drive = 1'b0; end
            ST_RD_B:     pins.scl = 1'b0;
            ST_RD_C:     pins.scl = 1'b1;
            ST_NK_A:     begin pins.scl = 1'b0; pins.drive = 1'b1; end
            ST_NK_B:     begin pins.scl = 1'b0; pins.sda = 1'b1; end
            ST_NK_C:     pins.scl = 1'b1;
            ST_NK_D:     pins.scl = 1'b0;
            default:     ;
        endcase
    endtask

    task automatic load_byte(input logic [7:0] value);
        shift_reg = value;
        bits_done = '0;
        enter_slot(ST_BIT_LO);
    endtask

    task automatic next_phase();
        t_kind      kind;
        logic       searching;
        logic [6:0] dev;
        dev       = held_req.device_address;
        searching = 1'b1;
        while (searching) begin
            phase_idx = phase_idx + 4'd1;
            kind      = phase_kind(held_req.func == FUNC_READ, phase_idx);
            searching = 1'b0;
            case (kind)
                K_START:   enter_slot(ST_START_A);
                K_ADDRW:   load_byte({dev, 1'b0});
                K_REG:     load_byte(held_req.register_address);
                K_DATA:    load_byte(held_req.write_data);
                // Plain I2C runs straight on into the repeated start.
                K_MIDSTOP: begin
                    if (cfg_sccb) enter_slot(ST_STOP_A);
                    else searching = 1'b1;
                end
                K_ADDRR:   load_byte({dev, 1'b1});
                K_READ: begin
                    shift_reg = '0;
                    bits_done = '0;
                    enter_slot(ST_RD_PRE);
                end
                K_STOP:    enter_slot(ST_STOP_A);
                default: begin
                    bus_step   = ST_IDLE;
                    slot_count = '0;
                    seq_done   = 1'b1;
                end
            endcase
        end
    endtask

    task automatic finish_slot(input logic sda);
        case (bus_step)
            ST_START_A: enter_slot(ST_START_B);
            ST_START_B: begin pins.scl = 1'b0; next_phase(); end
            ST_BIT_LO:  enter_slot(ST_BIT_HI);
            ST_BIT_HI: begin
                shift_reg = {shift_reg[6:0], 1'b0};
                bits_done = bits_done + 4'd1;
                enter_slot(bits_done >= 4'd8 ? ST_ACK_LO : ST_BIT_LO);
            end
            ST_ACK_LO:  enter_slot(ST_ACK_HI);
            ST_ACK_HI: begin
                // A missing acknowledge skips the trailing low slot.
                if (sda) begin
                    nack_seen  = 1'b1;
                    pins.drive = 1'b1;
                    pins.scl   = 1'b0;
                    next_phase();
                end else begin
                    enter_slot(ST_ACK_TAIL);
                end
            end
            ST_ACK_TAIL: next_phase();
            ST_STOP_A:   enter_slot(ST_STOP_B);
            ST_STOP_B:   enter_slot(ST_STOP_C);
            ST_STOP_C:   next_phase();
            ST_RD_PRE:   enter_slot(ST_RD_A);
            ST_RD_A:     enter_slot(ST_RD_B);
            ST_RD_B:     enter_slot(ST_RD_C);
            ST_RD_C: begin
                shift_reg = {shift_reg[6:0], sda};
                bits_done = bits_done + 4'd1;
                if (bits_done >= 4'd8) begin
                    last_rx = shift_reg;
                    enter_slot(ST_NK_A);
                end else begin
                    enter_slot(ST_RD_A);
                end
            end
            ST_NK_A: enter_slot(ST_NK_B);
            ST_NK_B: enter_slot(ST_NK_C);
            ST_NK_C: enter_slot(ST_NK_D);
            ST_NK_D: next_phase();
            default: begin
                bus_step   = ST_IDLE;
                slot_count = '0;
            end
        endcase
    endtask

    task automatic step_bus_master(input t_in it, output t_out res);
        logic [15:0] span;
        span     = (cfg_half == 16'd0) ? 16'd1 : cfg_half;
        seq_done = 1'b0;
        if (bus_step == ST_IDLE) begin
            if (it.func == FUNC_WRITE || it.func == FUNC_READ) begin
                held_req  = '{it.func, it.device_address, it.register_address, it.write_data};
                nack_seen = 1'b0;
                phase_idx = '0;
                enter_slot(ST_START_A);
            end
        end else begin
            slot_count = slot_count + 16'd1;
            if (slot_count >= span) begin
                slot_count = '0;
                finish_slot(it.sda_level);
            end
        end
        res.scl_level     = pins.scl;
        res.sda_out_level = pins.sda;
        res.sda_is_output = pins.drive;
        res.busy_res      = (bus_step != ST_IDLE);
        res.done_res      = seq_done;
        res.read_data     = last_rx;
        res.ack_missing   = nack_seen;
    endtask

    task automatic reset_bus_master();
        cfg_half   = HALF_RESET;
        cfg_sccb   = 1'b0;
        bus_step   = ST_IDLE;
        slot_count = '0;
        shift_reg  = '0;
        bits_done  = '0;
        held_req   = '0;
        last_rx    = '0;
        nack_seen  = 1'b0;
        pins       = '{1'b1, 1'b1, 1'b1};
        phase_idx  = '0;
        seq_done   = 1'b0;
    endtask

    // ---------------------------------------------------------------- result side

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_levels = o_out_data;
            if (pending_levels.size() == 0) begin
                $display("%0t: result transfer with nothing expected: expected none, actual %h",
                         $time, seen_levels);
                fail_count++;
            end else begin
                due_levels = pending_levels.pop_front();
                check_field("scl_level", 8'(due_levels.scl_level), 8'(seen_levels.scl_level));
                check_field("sda_out_level", 8'(due_levels.sda_out_level),
                            8'(seen_levels.sda_out_level));
                check_field("sda_is_output", 8'(due_levels.sda_is_output),
                            8'(seen_levels.sda_is_output));
                check_field("busy_res", 8'(due_levels.busy_res), 8'(seen_levels.busy_res));
                check_field("done_res", 8'(due_levels.done_res), 8'(seen_levels.done_res));
                check_field("read_data", due_levels.read_data, seen_levels.read_data);
                check_field("ack_missing", 8'(due_levels.ack_missing),
                            8'(seen_levels.ack_missing));
            end
        end
    end

    // The receiver changes its stall pattern now and then, and once holds off for a
    // long stretch so that the block fills up and refuses further ticks.
    always @(negedge i_clk) begin
        if (!long_hold_done && accepted_items >= HOLD_AT) begin
            long_hold_done = 1'b1;
            hold_left      = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_pattern = t_rx_pattern'($urandom_range(0, 3));
                rx_left    = $urandom_range(8, 80);
            end
            rx_left--;
            case (rx_pattern)
                RX_OPEN:         i_out_ready <= 1'b1;
                RX_SPARSE_STALL: i_out_ready <= ($urandom_range(0, 3) != 0);
                RX_ALTERNATE:    i_out_ready <= rx_left[0];
                default:         i_out_ready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    // ---------------------------------------------------------------- tick side

    // Bursts of back-to-back ticks separated by random gaps.
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
    endtask

    task automatic offer(input t_in it, input logic typed, input t_out want);
        t_out predicted;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        step_bus_master(it, predicted);
        pending_levels.push_back(typed ? want : predicted);
        accepted_items++;
    endtask

    // Requests are mostly offered while the bus is free; acknowledges are mostly good.
    function automatic t_in make_tick();
        t_in it;
        int  pick;
        it.device_address   = 7'($urandom_range(0, 127));
        it.register_address = 8'($urandom_range(0, 255));
        it.write_data       = 8'($urandom_range(0, 255));
        if (bus_step == ST_IDLE) begin
            pick = $urandom_range(0, 19);
            if (pick < 9)       it.func = FUNC_WRITE;
            else if (pick < 18) it.func = FUNC_READ;
            else if (pick < 19) it.func = FUNC_NONE;
            else                it.func = FUNC_RSVD;
        end else begin
            it.func = t_func'($urandom_range(0, 3));
        end
        if (bus_step == ST_ACK_LO || bus_step == ST_ACK_HI)
            it.sda_level = ($urandom_range(0, 7) == 0);
        else
            it.sda_level = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic settle_and_configure(input logic [15:0] half, input logic sccb);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_HALF_PERIOD;
        i_cfg_data  <= half;
        @(negedge i_clk);
        i_cfg_index <= REG_SCCB_MODE;
        i_cfg_data  <= {15'd0, sccb};
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_half   = half;
        cfg_sccb   = sccb;
        burst_left = 0;
    endtask

    initial begin
        int          ph;
        int          count;
        logic [15:0] half;
        logic        sccb;
        t_in         it;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_HALF_PERIOD;
        i_cfg_data  = '0;
        reset_bus_master();

        // Reset settings throughout: a slot lasts 120 ticks, so the start slot
        // holds for every later row and busy requests are plainly ignored.
        dir_rows[0]  = '{'{FUNC_NONE,  7'h00, 8'h00, 8'h00, 1'b0}, 1'b1, IDLE_LEVELS};
        dir_rows[1]  = '{'{FUNC_NONE,  7'h7F, 8'hFF, 8'hFF, 1'b1}, 1'b1, IDLE_LEVELS};
        dir_rows[2]  = '{'{FUNC_RSVD,  7'h7F, 8'hFF, 8'hFF, 1'b1}, 1'b1, IDLE_LEVELS};
        dir_rows[3]  = '{'{FUNC_RSVD,  7'h00, 8'h00, 8'h00, 1'b0}, 1'b1, IDLE_LEVELS};
        dir_rows[4]  = '{'{FUNC_READ,  7'h7F, 8'hFF, 8'h00, 1'b0}, 1'b1, START_LEVELS};
        dir_rows[5]  = '{'{FUNC_WRITE, 7'h00, 8'h00, 8'hFF, 1'b1}, 1'b1, START_LEVELS};
        dir_rows[6]  = '{'{FUNC_RSVD,  7'h7F, 8'h00, 8'hFF, 1'b0}, 1'b1, START_LEVELS};
        dir_rows[7]  = '{'{FUNC_NONE,  7'h2A, 8'h5A, 8'hA5, 1'b1}, 1'b1, START_LEVELS};
        dir_rows[8]  = '{'{FUNC_READ,  7'h55, 8'hAA, 8'h55, 1'b0}, 1'b0, IDLE_LEVELS};
        dir_rows[9]  = '{'{FUNC_WRITE, 7'h7F, 8'hFF, 8'hFF, 1'b1}, 1'b0, IDLE_LEVELS};
        dir_rows[10] = '{'{FUNC_NONE,  7'h00, 8'h00, 8'h00, 1'b1}, 1'b0, IDLE_LEVELS};

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            pace();
            offer(dir_rows[r].stim, dir_rows[r].typed, dir_rows[r].want);
        end

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin half = 16'd1;     sccb = 1'b0; count = 250; end
                1: begin half = 16'd0;     sccb = 1'b1; count = 250; end
                2: begin half = 16'd2;     sccb = 1'b1; count = 250; end
                3: begin half = 16'hFFFF;  sccb = 1'b0; count = 60;  end
                4: begin half = 16'd0;     sccb = 1'b0; count = 250; end
                5: begin
                    half  = 16'($urandom_range(0, 65535));
                    sccb  = 1'($urandom_range(0, 1));
                    count = 60;
                end
                6: begin half = 16'd3;     sccb = 1'b1; count = 250; end
                default: begin half = 16'd1; sccb = 1'b1; count = 250; end
            endcase
            settle_and_configure(half, sccb);
            repeat (count) begin
                pace();
                it = make_tick();
                offer(it, 1'b0, IDLE_LEVELS);
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("** i2c_sccb_register_master: PASSED **");
        else
            $display("** i2c_sccb_register_master: FAILED **");
        $finish;
    end

endmodule

// ===== i2c_sccb_register_master.f =====
+incdir+rtl/core
rtl/core/isrm_pkg.sv
rtl/core/isrm_sequencer.sv
rtl/core/i2c_sccb_register_master.sv
rtl/core/isrm_checker.sv
tb/tb_i2c_sccb_register_master.sv
